### hdl/bfr_pkg.sv
// Shared types and constants for the backlight fade ramp unit.
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

	// Table geometry and level scale.
	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LEVEL_W     = 11;
	localparam int LEVEL_SHIFT = 10;
	localparam int RAW_W       = 16;
	localparam int COUNT_W     = 7;
	localparam int FRAC_W      = LEVEL_SHIFT;
	localparam int PROD_W      = LEVEL_W + ADDR_W;
	localparam int IDX_W       = PROD_W - LEVEL_SHIFT;
	localparam int IPROD_W     = RAW_W + FRAC_W;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(1024);

	// Ramp stage spans and steps.
	localparam logic [LEVEL_W-1:0] SPAN_FINE = LEVEL_W'(16);
	localparam logic [LEVEL_W-1:0] SPAN_MID  = LEVEL_W'(64);
	localparam logic [1:0] STAGE_FINE   = 2'd0;
	localparam logic [1:0] STAGE_MID    = 2'd1;
	localparam logic [1:0] STAGE_COARSE = 2'd2;
	localparam logic [4:0] STEP_FINE    = 5'd1;
	localparam logic [4:0] STEP_MID     = 5'd4;
	localparam logic [4:0] STEP_COARSE  = 5'd16;

	// Action codes carried in the input tuser.
	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_TARGET = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LEVEL_COUNT = 2'd0;
	localparam logic [1:0] CFG_RAW_FLOOR   = 2'd1;
	localparam logic [1:0] CFG_RAW_CEILING = 2'd2;
	localparam logic [1:0] CFG_SMOOTH      = 2'd3;

	// Mapping settings handed to the interpolator.
	typedef struct packed {
		logic [COUNT_W-1:0] level_count;
		logic [RAW_W-1:0]   raw_floor;
		logic [RAW_W-1:0]   raw_ceiling;
	} map_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_OUT
	} ctrl_state_t;

endpackage

`default_nettype wire

### hdl/bfr_table_ram.sv
// Raw level table: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module bfr_table_ram (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [bfr_pkg::ADDR_W-1:0] waddr,
	input  wire logic [bfr_pkg::RAW_W-1:0]  wdata,
	input  wire logic [bfr_pkg::ADDR_W-1:0] raddr_a,
	input  wire logic [bfr_pkg::ADDR_W-1:0] raddr_b,
	output logic      [bfr_pkg::RAW_W-1:0]  rdata_a,
	output logic      [bfr_pkg::RAW_W-1:0]  rdata_b
);
	import bfr_pkg::*;

	logic [RAW_W-1:0] mem [TABLE_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

### hdl/bfr_interp.sv
// Level to raw mapping: table lookup, linear interpolation and clamping.
`timescale 1ns / 1ps
`default_nettype none

module bfr_interp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bfr_pkg::LEVEL_W-1:0] level,
	input  wire bfr_pkg::map_cfg_t          cfg,
	output logic      [bfr_pkg::ADDR_W-1:0]  raddr_a,
	output logic      [bfr_pkg::ADDR_W-1:0]  raddr_b,
	input  wire logic [bfr_pkg::RAW_W-1:0]   rdata_a,
	input  wire logic [bfr_pkg::RAW_W-1:0]   rdata_b,
	output logic                             done,
	output logic      [bfr_pkg::RAW_W-1:0]   raw
);
	import bfr_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [COUNT_W-1:0] count_used;
	logic [ADDR_W-1:0]  last_idx;
	logic [PROD_W-1:0]  pos_prod;
	logic [IDX_W-1:0]   idx_full;
	logic [ADDR_W-1:0]  idx;

	logic [ADDR_W-1:0]  idx_s1;
	logic [FRAC_W-1:0]  rem_s1, rem_s2, rem_s3;
	logic               has_hi_s1, has_hi_s2;

	logic               down;
	logic [RAW_W-1:0]   diff;
	logic [RAW_W-1:0]   lo_s3, lo_s4;
	logic [RAW_W-1:0]   diff_s3;
	logic               down_s3, down_s4;
	logic [IPROD_W-1:0] prod_s4;

	logic [RAW_W-1:0]   delta;
	logic [RAW_W-1:0]   val;
	logic [RAW_W-1:0]   capped;
	logic [RAW_W-1:0]   floored;

	// Position of the level along the used part of the table.
	always_comb begin
		if (cfg.level_count < COUNT_W'(2)) begin
			count_used = COUNT_W'(2);
		end else if (cfg.level_count > COUNT_W'(TABLE_DEPTH)) begin
			count_used = COUNT_W'(TABLE_DEPTH);
		end else begin
			count_used = cfg.level_count;
		end
		last_idx = ADDR_W'(count_used - COUNT_W'(1));
		pos_prod = PROD_W'(level) * PROD_W'(last_idx);
		idx_full = pos_prod[PROD_W-1:LEVEL_SHIFT];
		if (idx_full > IDX_W'(last_idx)) begin
			idx = last_idx;
		end else begin
			idx = idx_full[ADDR_W-1:0];
		end
	end

	// Stage valid chain; one mapping is in flight at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: segment index and fraction.
	always_ff @(posedge clk) begin
		if (start) begin
			idx_s1    <= idx;
			rem_s1    <= pos_prod[FRAC_W-1:0];
			has_hi_s1 <= (idx < last_idx);
		end
	end

	// Both segment ends are read in the same cycle.
	assign raddr_a = idx_s1;
	assign raddr_b = idx_s1 + ADDR_W'(1);

	// Stage 2: table read in progress.
	always_ff @(posedge clk) begin
		rem_s2    <= rem_s1;
		has_hi_s2 <= has_hi_s1;
	end

	// Stage 3: span and direction of the segment.
	always_comb begin
		down = 1'b0;
		diff = '0;
		if (has_hi_s2) begin
			if (rdata_b >= rdata_a) begin
				diff = rdata_b - rdata_a;
			end else begin
				down = 1'b1;
				diff = rdata_a - rdata_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_s3   <= rdata_a;
		diff_s3 <= diff;
		down_s3 <= down;
		rem_s3  <= rem_s2;
	end

	// Stage 4: prorate the span by the fraction.
	always_ff @(posedge clk) begin
		prod_s4 <= IPROD_W'(diff_s3) * IPROD_W'(rem_s3);
		lo_s4   <= lo_s3;
		down_s4 <= down_s3;
	end

	// Stage 5: apply the offset, then ceiling, then floor for nonzero values.
	always_comb begin
		delta = prod_s4[IPROD_W-1:FRAC_W];
		val   = down_s4 ? (lo_s4 - delta) : (lo_s4 + delta);
		capped = (val > cfg.raw_ceiling) ? cfg.raw_ceiling : val;
		if (capped != '0 && capped < cfg.raw_floor) begin
			floored = cfg.raw_floor;
		end else begin
			floored = capped;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			raw <= floored;
		end
	end

	assign done = v_s5;

endmodule

`default_nettype wire

### hdl/backlight_fade_ramp_unit.sv
// Backlight fade ramp unit: ramp control, configuration and result register.
//
// The unit takes one beat at a time. A table write, or a command or tick that
// drives nothing, goes from acceptance straight to ST_OUT, where its result
// is loaded, and the next beat can be taken once that is done. A beat that
// applies a new level waits in ST_MAP for the mapping before ST_OUT. The raw
// table sits in a two-read-port memory with registered output, and the
// mapping runs through a five-stage interpolator (position multiply, table
// read, span, prorating multiply, clamp). The mapped value is held in a
// register before it reaches the result register. A result waiting in the
// output register does not hold off the next input beat; the loading of the
// following result waits for it to be taken, and no further beat is taken
// before that load. Table entries have no reset and must be written before a
// level that maps onto them is applied.
`timescale 1ns / 1ps
`default_nettype none

module backlight_fade_ramp_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input beats.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// entry_index[5:0], entry_value[21:6], level[32:22], zero fill
	input  wire logic [39:0] s_tdata,
	// action[1:0]
	input  wire logic [1:0]  s_tuser,
	// Result beats.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// raw_level[15:0], drove[16], current_level[27:17], target_level[38:28],
	// moving[39]
	output logic      [39:0] m_tdata,
	// Configuration writes.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import bfr_pkg::*;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [1:0]         stage;
	} ramp_t;

	// One ramp step from present toward goal, narrowing the stage first.
	function automatic ramp_t ramp_step(input logic [LEVEL_W-1:0] goal,
			input logic [LEVEL_W-1:0] present, input logic [1:0] stage);
		logic [LEVEL_W-1:0] d;
		logic [1:0]         st;
		logic [4:0]         s;
		ramp_t              r;
		d  = (goal > present) ? (goal - present) : (present - goal);
		st = (stage > STAGE_COARSE) ? STAGE_COARSE : stage;
		if (st == STAGE_COARSE && d <= SPAN_MID) begin
			st = STAGE_MID;
		end else if (st == STAGE_MID && d <= SPAN_FINE) begin
			st = STAGE_FINE;
		end
		case (st)
			STAGE_FINE: s = STEP_FINE;
			STAGE_MID:  s = STEP_MID;
			default:    s = STEP_COARSE;
		endcase
		if (d < LEVEL_W'(s)) begin
			r.level = goal;
		end else if (goal > present) begin
			r.level = present + LEVEL_W'(s);
		end else begin
			r.level = present - LEVEL_W'(s);
		end
		r.stage = st;
		return r;
	endfunction

	ctrl_state_t        state_q, state_d;
	logic [COUNT_W-1:0] level_count_q;
	logic [RAW_W-1:0]   raw_floor_q;
	logic [RAW_W-1:0]   raw_ceiling_q;
	logic               smooth_q;
	logic [LEVEL_W-1:0] present_q, present_d;
	logic [LEVEL_W-1:0] goal_q, goal_d;
	logic [1:0]         stage_q, stage_d;
	logic               drove_q, drove_d;
	logic [RAW_W-1:0]   last_raw_q;
	logic               m_tvalid_q;
	logic [39:0]        m_tdata_q;
	logic               out_load;
	logic               map_start;
	logic               map_start_q;

	logic [1:0]         action;
	logic [ADDR_W-1:0]  entry_index;
	logic [RAW_W-1:0]   entry_value;
	logic [LEVEL_W-1:0] level_in;
	logic [LEVEL_W-1:0] level_sat;
	logic [LEVEL_W-1:0] cmd_dist;
	logic [1:0]         cmd_stage;
	ramp_t              step_cmd;
	ramp_t              step_run;
	logic               ram_we;

	map_cfg_t           map_cfg;
	logic [ADDR_W-1:0]  raddr_a, raddr_b;
	logic [RAW_W-1:0]   rdata_a, rdata_b;
	logic               map_done;
	logic [RAW_W-1:0]   map_raw;

	// Unpack the input beat.
	assign action      = s_tuser;
	assign entry_index = s_tdata[5:0];
	assign entry_value = s_tdata[21:6];
	assign level_in    = s_tdata[32:22];
	assign level_sat   = (level_in > LEVEL_FULL) ? LEVEL_FULL : level_in;

	// Stage picked by a new target, and the two candidate ramp steps.
	assign cmd_dist = (level_sat > present_q) ? (level_sat - present_q)
		: (present_q - level_sat);
	assign cmd_stage = (cmd_dist <= SPAN_FINE) ? STAGE_FINE
		: ((cmd_dist <= SPAN_MID) ? STAGE_MID : STAGE_COARSE);
	assign step_cmd = ramp_step(level_sat, present_q, cmd_stage);
	assign step_run = ramp_step(goal_q, present_q, stage_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= COUNT_W'(2);
			raw_floor_q   <= '0;
			raw_ceiling_q <= '1;
			smooth_q      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEVEL_COUNT: level_count_q <= cfg_data[COUNT_W-1:0];
				CFG_RAW_FLOOR:   raw_floor_q   <= cfg_data;
				CFG_RAW_CEILING: raw_ceiling_q <= cfg_data;
				CFG_SMOOTH:      smooth_q      <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// Control state and ramp registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			present_q   <= '0;
			goal_q      <= '0;
			stage_q     <= STAGE_FINE;
			drove_q     <= 1'b0;
			last_raw_q  <= '0;
			map_start_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			present_q   <= present_d;
			goal_q      <= goal_d;
			stage_q     <= stage_d;
			drove_q     <= drove_d;
			map_start_q <= map_start;
			if (map_done) begin
				last_raw_q <= map_raw;
			end
		end
	end

	// Next state, ramp update and handshake.
	always_comb begin
		state_d   = state_q;
		present_d = present_q;
		goal_d    = goal_q;
		stage_d   = stage_q;
		drove_d   = drove_q;
		s_tready  = (state_q == ST_IDLE);
		ram_we    = 1'b0;
		map_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					drove_d = 1'b0;
					case (action)
						ACT_WRITE: begin
							ram_we = 1'b1;
						end
						ACT_TARGET: begin
							if (!smooth_q) begin
								present_d = level_sat;
								goal_d    = level_sat;
								drove_d   = 1'b1;
							end else if (level_sat != goal_q) begin
								goal_d  = level_sat;
								stage_d = cmd_stage;
								if (present_q == goal_q) begin
									present_d = step_cmd.level;
									stage_d   = step_cmd.stage;
									drove_d   = 1'b1;
								end
							end else if (present_q == goal_q) begin
								drove_d = 1'b1;
							end
						end
						ACT_TICK: begin
							if (present_q != goal_q) begin
								present_d = step_run.level;
								stage_d   = step_run.stage;
								drove_d   = 1'b1;
							end
						end
						default: ;
					endcase
					map_start = drove_d;
					state_d   = drove_d ? ST_MAP : ST_OUT;
				end
			end
			ST_MAP: begin
				if (map_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {(present_q != goal_q), goal_q, present_q, drove_q, last_raw_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign map_cfg.level_count = level_count_q;
	assign map_cfg.raw_floor   = raw_floor_q;
	assign map_cfg.raw_ceiling = raw_ceiling_q;

	bfr_table_ram u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (entry_index),
		.wdata   (entry_value),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// The mapping starts in the cycle after acceptance, from the registered level.
	bfr_interp u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (map_start_q),
		.level   (present_q),
		.cfg     (map_cfg),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.done    (map_done),
		.raw     (map_raw)
	);

endmodule

`default_nettype wire
